// ----- hdl/positional_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// positional list engine assertion macros
// shared concurrent property wrappers, clocked on the rising edge and
// disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define PLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list engine assertion failed");

// next-cycle implication
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list engine assertion failed");

`endif

// ----- hdl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// widths, operation and status codes, and the command broadcast to the cells
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int POS_W        = 7;
    localparam int STAT_W       = 3;
    localparam int IDX_W        = 6;
    localparam int DEF_CAPACITY = 16;
    localparam int MAX_RESULTS  = 16;

    localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OP_W-1:0] OP_MODIFY  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT    = 3'd4;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP    = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_DELETE = 3'd2;
    localparam logic [2:0] CELL_WRITE  = 3'd3;
    localparam logic [2:0] CELL_ROTATE = 3'd4;
    localparam logic [2:0] CELL_SORT   = 3'd5;

    typedef struct packed {
        logic [2:0]               code;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         end_idx;
        logic [POS_W-1:0]         count;
        logic                     parity;
    } cell_cmd_t;

endpackage

// ----- hdl/ple_in_if.sv -----
// ----------------------------------------------------------------------------
// ple_in_if
// operation channel: one transfer carries one list operation
// ----------------------------------------------------------------------------
interface ple_in_if;

    logic                              valid;
    logic                              ready;
    logic [ple_pkg::OP_W-1:0]          operation;
    logic signed [ple_pkg::DATA_W-1:0] item_value;
    logic [ple_pkg::POS_W-1:0]         position;

    modport source (output valid, output operation, output item_value, output position,
                    input ready);
    modport sink   (input valid, input operation, input item_value, input position,
                    output ready);

endinterface

// ----- hdl/ple_out_if.sv -----
// ----------------------------------------------------------------------------
// ple_out_if
// result channel: one transfer carries one result of an operation
// ----------------------------------------------------------------------------
interface ple_out_if;

    logic                              valid;
    logic                              ready;
    logic [ple_pkg::STAT_W-1:0]        status;
    logic [ple_pkg::IDX_W-1:0]         found_index;
    logic signed [ple_pkg::DATA_W-1:0] element_value;
    logic [ple_pkg::POS_W-1:0]         list_length;
    logic                              last;

    modport source (output valid, output status, output found_index, output element_value,
                    output list_length, output last, input ready);
    modport sink   (input valid, input status, input found_index, input element_value,
                    input list_length, input last, output ready);

endinterface

// ----- hdl/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: takes its left or right neighbor, the head, a new value or
// the min/max of a neighbor pair, as the broadcast command says
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  ple_pkg::cell_cmd_t                cmd,
    input  logic signed [ple_pkg::DATA_W-1:0] head,
    input  logic signed [ple_pkg::DATA_W-1:0] left,
    input  logic signed [ple_pkg::DATA_W-1:0] right,
    output logic signed [ple_pkg::DATA_W-1:0] value
);

    localparam logic [ple_pkg::POS_W-1:0] IDX_P  = ple_pkg::POS_W'(IDX);
    localparam logic [ple_pkg::POS_W-1:0] IDX_P1 = ple_pkg::POS_W'(IDX + 1);
    localparam logic                      PAR    = 1'(IDX % 2);

    logic signed [ple_pkg::DATA_W-1:0] value_reg;
    logic signed [ple_pkg::DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.code)
            ple_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
            ple_pkg::CELL_INSERT:
            begin
                if (IDX_P > cmd.pos)
                    value_next = left;
                else if (IDX_P == cmd.pos)
                    value_next = cmd.val;
            end
            ple_pkg::CELL_DELETE:
            begin
                if (IDX_P >= cmd.pos)
                    value_next = right;
            end
            ple_pkg::CELL_WRITE:
            begin
                if (IDX_P == cmd.pos)
                    value_next = cmd.val;
            end
            ple_pkg::CELL_ROTATE:
            begin
                if (IDX_P < cmd.end_idx)
                    value_next = right;
                else if (IDX_P == cmd.end_idx)
                    value_next = head;
            end
            ple_pkg::CELL_SORT:
            begin
                // lower member of a pair keeps the min, upper keeps the max
                if ((PAR == cmd.parity) && (IDX_P1 < cmd.count))
                begin
                    if (value_reg > right)
                        value_next = right;
                end
                else if ((PAR != cmd.parity) && (IDX != 0) && (IDX_P < cmd.count))
                begin
                    if (left > value_reg)
                        value_next = left;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- hdl/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// ple_ctrl
// operation sequencer: checks positions, steps the cell chain through
// rotate and sort passes, and drives the registered result stage
// ----------------------------------------------------------------------------
`include "positional_list_engine_defines.svh"

module ple_ctrl #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ple_in_if.sink                            req,
    ple_out_if.source                         rsp,
    input  logic signed [ple_pkg::DATA_W-1:0] head,
    output ple_pkg::cell_cmd_t                cmd
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = ple_pkg::POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_DUMP = 3'd3;
    localparam logic [2:0] S_SORT = 3'd4;
    localparam logic [2:0] S_REV  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              out_valid_reg, out_valid_next;
    logic [ple_pkg::OP_W-1:0]          op_reg, op_next;
    logic signed [ple_pkg::DATA_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]                  pos_reg, pos_next;
    logic [CNT_W-1:0]                  step_reg, step_next;
    logic [ple_pkg::STAT_W-1:0]        status_reg, status_next;
    logic [ple_pkg::IDX_W-1:0]         found_reg, found_next;
    logic                              hit_reg, hit_next;
    logic [ple_pkg::STAT_W-1:0]        o_status_reg, o_status_next;
    logic [ple_pkg::IDX_W-1:0]         o_found_reg, o_found_next;
    logic signed [ple_pkg::DATA_W-1:0] o_elem_reg, o_elem_next;
    logic [POS_W-1:0]                  o_len_reg, o_len_next;
    logic                              o_last_reg, o_last_next;

    logic             slot_free;
    logic [POS_W-1:0] count_w;
    logic [POS_W-1:0] dump_cnt;
    logic [POS_W-1:0] rot_end;
    logic             dump_emit;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign count_w   = POS_W'(count_reg);
    assign dump_cnt  = (count_w < POS_W'(ple_pkg::MAX_RESULTS)) ? count_w
                                                               : POS_W'(ple_pkg::MAX_RESULTS);
    assign rot_end   = POS_W'(count_reg - CNT_W'(1));
    assign dump_emit = POS_W'(step_reg) < dump_cnt;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        o_status_next  = o_status_reg;
        o_found_next   = o_found_reg;
        o_elem_next    = o_elem_reg;
        o_len_next     = o_len_reg;
        o_last_next    = o_last_reg;
        cmd.code       = ple_pkg::CELL_HOLD;
        cmd.pos        = pos_reg;
        cmd.val        = val_reg;
        cmd.end_idx    = rot_end;
        cmd.count      = count_w;
        cmd.parity     = step_reg[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    val_next   = req.item_value;
                    pos_next   = req.position;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ple_pkg::ST_OK;
                found_next  = '0;
                hit_next    = 1'b0;
                step_next   = '0;
                state_next  = S_RESP;
                unique case (op_reg)
                    ple_pkg::OP_INSERT:
                    begin
                        if (pos_reg > count_w)
                            status_next = ple_pkg::ST_BAD_POS;
                        else if (count_reg == CNT_W'(CAPACITY))
                            status_next = ple_pkg::ST_FULL;
                        else
                        begin
                            cmd.code   = ple_pkg::CELL_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    ple_pkg::OP_DELETE:
                    begin
                        if (count_reg == '0)
                            status_next = ple_pkg::ST_EMPTY;
                        else if (pos_reg >= count_w)
                            status_next = ple_pkg::ST_BAD_POS;
                        else
                        begin
                            cmd.code   = ple_pkg::CELL_DELETE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    ple_pkg::OP_MODIFY:
                    begin
                        if (count_reg == '0)
                            status_next = ple_pkg::ST_EMPTY;
                        else if (pos_reg >= count_w)
                            status_next = ple_pkg::ST_BAD_POS;
                        else
                            cmd.code = ple_pkg::CELL_WRITE;
                    end
                    ple_pkg::OP_FIND:
                    begin
                        state_next = S_FIND;
                    end
                    ple_pkg::OP_SORT:
                    begin
                        if (count_reg == '0)
                            status_next = ple_pkg::ST_EMPTY;
                        else
                            state_next = S_SORT;
                    end
                    ple_pkg::OP_REVERSE:
                    begin
                        if (count_reg > CNT_W'(1))
                        begin
                            step_next  = count_reg - CNT_W'(1);
                            state_next = S_REV;
                        end
                    end
                    ple_pkg::OP_DUMP:
                    begin
                        if (count_reg == '0)
                            status_next = ple_pkg::ST_EMPTY;
                        else
                            state_next = S_DUMP;
                    end
                    default:
                    begin
                        status_next = ple_pkg::ST_OK;
                    end
                endcase
            end
            S_FIND:
            begin
                // full rotation brings the list back to its original order
                if (step_reg < count_reg)
                begin
                    if (!hit_reg && (head == val_reg))
                    begin
                        hit_next   = 1'b1;
                        found_next = ple_pkg::IDX_W'(step_reg);
                    end
                    cmd.code  = ple_pkg::CELL_ROTATE;
                    step_next = step_reg + CNT_W'(1);
                end
                else
                begin
                    status_next = hit_reg ? ple_pkg::ST_OK : ple_pkg::ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
            end
            S_DUMP:
            begin
                if (!dump_emit || slot_free)
                begin
                    cmd.code  = ple_pkg::CELL_ROTATE;
                    step_next = step_reg + CNT_W'(1);
                    if (dump_emit)
                    begin
                        out_valid_next = 1'b1;
                        o_status_next  = ple_pkg::ST_OK;
                        o_found_next   = '0;
                        o_elem_next    = head;
                        o_len_next     = count_w;
                        o_last_next    = (POS_W'(step_reg) + POS_W'(1)) == dump_cnt;
                    end
                    if (step_reg == count_reg - CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            S_SORT:
            begin
                cmd.code  = ple_pkg::CELL_SORT;
                step_next = step_reg + CNT_W'(1);
                if (step_reg == count_reg - CNT_W'(1))
                    state_next = S_RESP;
            end
            S_REV:
            begin
                // rotate ever shorter prefixes: the head lands at the prefix end
                cmd.code    = ple_pkg::CELL_ROTATE;
                cmd.end_idx = POS_W'(step_reg);
                step_next   = step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_found_next   = found_reg;
                    o_elem_next    = '0;
                    o_len_next     = count_w;
                    o_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        step_reg     <= step_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        o_status_reg <= o_status_next;
        o_found_reg  <= o_found_next;
        o_elem_reg   <= o_elem_next;
        o_len_reg    <= o_len_next;
        o_last_reg   <= o_last_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.found_index   = o_found_reg;
    assign rsp.element_value = o_elem_reg;
    assign rsp.list_length   = o_len_reg;
    assign rsp.last          = o_last_reg;

    `PLE_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `PLE_ASSERT_NEXT(a_accept_exec, clk, rst_n, req.valid && req.ready, state_reg == S_EXEC)
    `PLE_ASSERT_NEXT(a_count_only_exec, clk, rst_n, state_reg != S_EXEC, $stable(count_reg))
    `PLE_ASSERT_IMPLIES(a_dump_step, clk, rst_n, state_reg == S_DUMP, step_reg < count_reg)

endmodule

// ----- hdl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values kept in a row of shifting cells
// ----------------------------------------------------------------------------
// One operation is taken at a time; the list lives in a chain of CAPACITY
// cells that shift one place per cycle while a shift command is broadcast.
// Insert, delete, modify and unused codes, and sort, reverse and dump of an
// empty list, go from the execute state straight to the result state; find
// rotates the chain once past the head comparator, sort runs n odd-even
// compare passes, with n the list length, reverse of two or more elements
// rotates ever shorter prefixes; a dump rotates the chain once and emits
// the head for at most MAX_RESULTS steps; result stalls hold it. A new
// operation is taken once the last result sits in the output register.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::DEF_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_in_if.sink    req,
    ple_out_if.source rsp
);

    ple_pkg::cell_cmd_t                cmd;
    logic signed [ple_pkg::DATA_W-1:0] cell_value [CAPACITY];

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .head  (cell_value[0]),
        .cmd   (cmd)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [ple_pkg::DATA_W-1:0] left_value;
        logic signed [ple_pkg::DATA_W-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = cell_value[i];
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_final
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        ple_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .head  (cell_value[0]),
            .left  (left_value),
            .right (right_value),
            .value (cell_value[i])
        );
    end

endmodule
